>>> rtl/yuv_rule_color_classifier_macros.svh
// assertion macros for the yuv rule colour classifier
`ifndef YUV_RULE_COLOR_CLASSIFIER_MACROS_SVH
`define YUV_RULE_COLOR_CLASSIFIER_MACROS_SVH
// assertion that holds outside reset
`define YRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion checked in every cycle including reset
`define YRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/yrc_pkg.sv
// package with types and constants of the yuv rule colour classifier
package yrc_pkg;
  localparam int unsigned HueNone = 3800;
  localparam int unsigned SatMax  = 511;
  localparam logic [2:0] CfgRule   = 3'd0;
  localparam logic [2:0] CfgCount  = 3'd1;
  localparam logic [2:0] CfgClass0 = 3'd2;

  // hue min sits in the low bits, class value in the top bits
  typedef struct packed {
    logic [3:0]  cls;
    logic [17:0] rad;
    logic [11:0] hmax;
    logic [11:0] hmin;
  } class_rule_t;

  typedef struct packed {
    logic [3:0]  black_cls;
    logic [8:0]  black_lim;
    logic [3:0]  gray_cls;
    logic [8:0]  gray_lim;
    logic [3:0]  white_cls;
    logic [17:0] white_rad;
  } rule_t;

  // fixed point coefficient, round half up
  function automatic int unsigned coef(input int unsigned k, input int unsigned fb);
    longint unsigned p;
    p = (longint'(k) << fb) + 64'd5000;
    return int'(p / 64'd10000);
  endfunction
endpackage

>>> rtl/yrc_stream_if.sv
// valid/ready channel with generic payload
interface yrc_stream_if #(parameter int unsigned W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/yrc_cfg_if.sv
// configuration write channel
interface yrc_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/yrc_divider.sv
// pipelined restoring divider, one quotient bit per stage
module yrc_divider #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 24,
  parameter int unsigned QW = 12,
  parameter int unsigned TW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);
  // numerator must be below den << QW for quotient without overflow;
  // the overflow flag marks quotients that need more than QW bits
  localparam int unsigned RW = DW + 1;
  logic [NW-1:0] n_r [QW+1];
  logic [RW-1:0] rem_r [QW+1];
  logic [DW-1:0] d_r [QW+1];
  logic [QW-1:0] q_r [QW+1];
  logic [TW-1:0] t_r [QW+1];
  logic          o_r [QW+1];

  always_comb begin
    n_r[0]   = num;
    d_r[0]   = den;
    t_r[0]   = tag;
    q_r[0]   = '0;
    // overflow when num >> QW >= den
    o_r[0]   = (NW > QW) ? ((num >> QW) >= NW'(den)) : 1'b0;
    rem_r[0] = RW'(num >> QW);
  end

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_st
      logic [RW-1:0] cand;
      logic          take;
      always_comb begin
        cand = {rem_r[s][RW-2:0], n_r[s][QW-1-s]};
        take = cand >= RW'(d_r[s]);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= take ? cand - RW'(d_r[s]) : cand;
          q_r[s+1]   <= {q_r[s][QW-2:0], take};
          n_r[s+1]   <= n_r[s];
          d_r[s+1]   <= d_r[s];
          t_r[s+1]   <= t_r[s];
          o_r[s+1]   <= o_r[s];
        end
      end
    end
  endgenerate

  assign quo     = q_r[QW];
  assign ovf     = o_r[QW];
  assign tag_out = t_r[QW];
endmodule

>>> rtl/yuv_rule_color_classifier.sv
// top level of the yuv rule colour classifier
//
// channel | dir | payload                                         | beat
// in_     | in  | luma, chroma_u, chroma_v                        | valid & ready
// out_    | out | class_value, class_bit, hue_tenths, inv_sat     | valid & ready
// cfg_    | in  | index, wdata                                    | valid & ready
//
// one pixel per cycle while the output is not stalled, through the pipeline;
// the thirteen-stage hue divider sets the depth (sat divider runs alongside)
// the whole pipe advances when the last stage is empty or taken
// reset clears valid bits and config registers; payload regs are not reset
`include "yuv_rule_color_classifier_macros.svh"
module yuv_rule_color_classifier #(
  parameter int unsigned MAX_CLASSES = 6,
  parameter int unsigned FRAC_BITS   = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_luma,
  input  logic [7:0] in_chroma_u,
  input  logic [7:0] in_chroma_v,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_class_value,
  output logic [7:0]  out_class_bit,
  output logic [11:0] out_hue_tenths,
  output logic [8:0]  out_inv_saturation,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  localparam int unsigned KA = yrc_pkg::coef(14075, FRAC_BITS);
  localparam int unsigned KB = yrc_pkg::coef(3455, FRAC_BITS);
  localparam int unsigned KC = yrc_pkg::coef(7169, FRAC_BITS);
  localparam int unsigned KD = yrc_pkg::coef(17790, FRAC_BITS);
  localparam int unsigned CW = FRAC_BITS + 8;       // clamped channel width
  localparam int unsigned SW = FRAC_BITS + 11;      // signed sum width
  localparam int unsigned NW = CW + 13;             // hue numerator
  localparam int unsigned DEPTH = 21;
  localparam logic [CW-1:0] TOP = CW'(255) << FRAC_BITS;

  // config registers
  yrc_pkg::rule_t       rule_r;
  logic [2:0]           count_r;
  yrc_pkg::class_rule_t cw_r [MAX_CLASSES];
  logic [2:0]           slot;
  assign cfg_ready = 1'b1;
  assign slot = cfg_index - yrc_pkg::CfgClass0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r  <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) cw_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == yrc_pkg::CfgRule) rule_r <= cfg_wdata;
      else if (cfg_index == yrc_pkg::CfgCount) count_r <= cfg_wdata[2:0];
      else if (cfg_index >= yrc_pkg::CfgClass0 && 32'(slot) < MAX_CLASSES)
        cw_r[slot] <= cfg_wdata[45:0];
    end
  end

  // pipeline advance
  logic [DEPTH-1:0] vld_r;
  logic en;
  assign en       = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end
  assign out_valid = vld_r[DEPTH-1];

  // stage 1: products
  logic [7:0] y1_r;
  logic signed [SW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [8:0] u_s, v_s;
  assign u_s = $signed({1'b0, in_chroma_u}) - 9'sd128;
  assign v_s = $signed({1'b0, in_chroma_v}) - 9'sd128;
  always_ff @(posedge clk) if (en) begin
    y1_r <= in_luma;
    pa_r <= SW'($signed(SW'(KA))) * SW'(v_s);
    pb_r <= SW'($signed(SW'(KB))) * SW'(u_s);
    pc_r <= SW'($signed(SW'(KC))) * SW'(v_s);
    pd_r <= SW'($signed(SW'(KD))) * SW'(u_s);
  end

  // stage 2: sums and clamps
  function automatic logic [CW-1:0] clampc(input logic signed [SW-1:0] x);
    if (x < 0) return '0;
    if (x > $signed(SW'(TOP))) return TOP;
    return x[CW-1:0];
  endfunction
  logic signed [SW-1:0] yf;
  assign yf = $signed(SW'(y1_r) << FRAC_BITS);
  logic [7:0] y2_r;
  logic [CW-1:0] r2_r, g2_r, b2_r;
  always_ff @(posedge clk) if (en) begin
    y2_r <= y1_r;
    r2_r <= clampc(yf + pa_r);
    g2_r <= clampc(yf - pb_r - pc_r);
    b2_r <= clampc(yf + pd_r);
  end

  // stage 3: max, min, numerators
  logic [CW-1:0] mx, mn;
  logic [NW-1:0] hnum, base;
  logic signed [CW:0] diff;
  logic [1:0] sel;
  always_comb begin
    mx = r2_r; mn = r2_r;
    if (g2_r > mx) mx = g2_r;
    if (b2_r > mx) mx = b2_r;
    if (g2_r < mn) mn = g2_r;
    if (b2_r < mn) mn = b2_r;
    if (mx == r2_r) begin
      sel = 2'd0; diff = $signed({1'b0, g2_r}) - $signed({1'b0, b2_r});
    end else if (mx == g2_r) begin
      sel = 2'd1; diff = $signed({1'b0, b2_r}) - $signed({1'b0, r2_r});
    end else begin
      sel = 2'd2; diff = $signed({1'b0, r2_r}) - $signed({1'b0, g2_r});
    end
  end
  logic [7:0] y3_r;
  logic [CW-1:0] d3_r, mn3_r;
  logic signed [NW:0] m3_r;
  logic [1:0] sel3_r;
  logic none3_r;
  always_ff @(posedge clk) if (en) begin
    y3_r   <= y2_r;
    d3_r   <= mx - mn;
    mn3_r  <= mn;
    m3_r   <= (NW+1)'(diff) * (NW+1)'(600);
    sel3_r <= sel;
    none3_r <= mx == mn;
  end

  // stage 4: add offset*d
  always_comb begin
    case (sel3_r)
      2'd0:    base = NW'(d3_r) * NW'(3600);
      2'd1:    base = NW'(d3_r) * NW'(1200);
      default: base = NW'(d3_r) * NW'(2400);
    endcase
    hnum = NW'(m3_r + $signed({1'b0, base}));
  end
  logic [NW-1:0] hn4_r;
  logic [CW-1:0] d4_r, sn4_r;
  logic [CW-1:0] sd4_r;
  logic [7:0] y4_r;
  logic sr4_r, none4_r;
  always_ff @(posedge clk) if (en) begin
    hn4_r   <= hnum;
    d4_r    <= none3_r ? CW'(1) : d3_r;
    sn4_r   <= mn3_r;
    sd4_r   <= (y3_r == 0) ? CW'(1) : (CW'(y3_r) << FRAC_BITS);
    y4_r    <= y3_r;
    sr4_r   <= sel3_r == 2'd0;
    none4_r <= none3_r;
  end

  // stages 5-17: hue and saturation dividers
  // red-max hues reach 4200 before the wrap, so the quotient needs 13 bits
  localparam int unsigned TG = 10;
  logic [12:0] hq;
  logic [TG-1:0] htag;
  logic hov;
  yrc_divider #(.NW(NW), .DW(CW), .QW(13), .TW(TG)) u_hue (
    .clk, .en, .num(hn4_r), .den(d4_r), .tag({y4_r, sr4_r, none4_r}),
    .quo(hq), .ovf(hov), .tag_out(htag)
  );
  // min*256/(y<<F) = (min>>F... ) exact: num = min*256, den = y<<F
  logic [8:0] sq;
  logic sov;
  logic [0:0] stag;
  yrc_divider #(.NW(CW+8), .DW(CW), .QW(9), .TW(1)) u_sat (
    .clk, .en, .num({sn4_r, 8'd0}), .den(sd4_r), .tag(1'b0),
    .quo(sq), .ovf(sov), .tag_out(stag)
  );
  // align 9-stage sat divider with 13-stage hue divider
  logic [9:0] sd_r [4];
  always_ff @(posedge clk) if (en) begin
    sd_r[0] <= {sq, sov};
    sd_r[1] <= sd_r[0];
    sd_r[2] <= sd_r[1];
    sd_r[3] <= sd_r[2];
  end

  // stage 18: hue wrap and saturation clamp
  logic [7:0] y17_r;
  logic [11:0] hue17_r;
  logic [8:0] sat17_r;
  always_ff @(posedge clk) if (en) begin
    y17_r   <= htag[9:2];
    if (htag[0]) hue17_r <= 12'(yrc_pkg::HueNone);
    else if (htag[1] && hq > 13'd3600) hue17_r <= 12'(hq - 13'd3600);
    else hue17_r <= 12'(hq);
    sat17_r <= (htag[9:2] == 0 || sd_r[3][0] || stag[0]) ? 9'(yrc_pkg::SatMax)
               : sd_r[3][9:1];
  end

  // stage 19: squared distances
  logic signed [9:0] ds_c, dl_c, dsw_c;
  logic signed [9:0] dlw_c;
  assign ds_c  = 10'sd24 - $signed({1'b0, sat17_r});
  assign dl_c  = 10'sd128 - $signed({2'b0, y17_r});
  assign dsw_c = 10'sd256 - $signed({1'b0, sat17_r});
  assign dlw_c = 10'sd256 - $signed({2'b0, y17_r});
  logic [18:0] dc18_r, dw18_r;
  logic [7:0] y18_r;
  logic [11:0] hue18_r;
  logic [8:0] sat18_r;
  always_ff @(posedge clk) if (en) begin
    dc18_r  <= 19'(19'(ds_c) * 19'(ds_c)) + 19'(19'(dl_c) * 19'(dl_c));
    dw18_r  <= 19'(19'(dsw_c) * 19'(dsw_c)) + 19'(19'(dlw_c) * 19'(dlw_c));
    y18_r   <= y17_r;
    hue18_r <= hue17_r;
    sat18_r <= sat17_r;
  end

  // stage 20: rule matching
  logic [3:0] cls;
  logic done;
  always_comb begin
    cls = 4'd0; done = 1'b0;
    if (9'(y18_r) < rule_r.black_lim) begin
      cls = rule_r.black_cls; done = 1'b1;
    end
    for (int i = 0; i < MAX_CLASSES; i++) begin
      if (!done && 32'(i) < 32'(count_r) && cw_r[i].hmin < hue18_r &&
          hue18_r < cw_r[i].hmax && dc18_r < 19'(cw_r[i].rad)) begin
        cls = cw_r[i].cls; done = 1'b1;
      end
    end
    if (!done && dw18_r < 19'(rule_r.white_rad)) begin
      cls = rule_r.white_cls; done = 1'b1;
    end
    if (!done && sat18_r > rule_r.gray_lim) cls = rule_r.gray_cls;
  end
  logic [3:0] cls_r;
  logic [11:0] hue19_r;
  logic [8:0] sat19_r;
  always_ff @(posedge clk) if (en) begin
    cls_r   <= cls;
    hue19_r <= hue18_r;
    sat19_r <= sat18_r;
  end

  // stage 21: output register
  logic [3:0] ocls_r;
  logic [7:0] obit_r;
  logic [11:0] ohue_r;
  logic [8:0] osat_r;
  always_ff @(posedge clk) if (en) begin
    ocls_r <= cls_r;
    obit_r <= (cls_r == 0 || cls_r > 4'd8) ? 8'd0 : 8'(8'd1 << (cls_r - 4'd1));
    ohue_r <= hue19_r;
    osat_r <= sat19_r;
  end
  assign out_class_value    = ocls_r;
  assign out_class_bit      = obit_r;
  assign out_hue_tenths     = ohue_r;
  assign out_inv_saturation = osat_r;

  // a stalled result holds until taken
  `YRC_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_class_value), "result lost under stall")
  // class bit has at most one bit set
  `YRC_ASSERT(a_onehot, out_valid |-> $onehot0(out_class_bit), "class bit not one-hot")
  // hue stays in range
  `YRC_ASSERT(a_hue, out_valid |-> out_hue_tenths <= 12'd3800, "hue out of range")
  // hue quotient always fits the divider
  `YRC_ASSERT(a_hue_fit, vld_r[16] |-> !hov, "hue quotient overflow")
  // reset empties the pipeline
  `YRC_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "valid after reset")
endmodule

>>> verif/yuv_rule_color_classifier_test.sv
// testbench for the yuv rule colour classifier: directed and random pixels against a local predictor
`timescale 1ns / 100ps
module yuv_rule_color_classifier_test;
  localparam int unsigned FB = 14;
  // fixed point colour conversion coefficients, rounded half up
  localparam longint K_RV = (64'd14075 * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam longint K_GU = (64'd3455 * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam longint K_GV = (64'd7169 * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam longint K_BU = (64'd17790 * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam int unsigned PIPE_DEPTH = 21;
  localparam int unsigned RULE_SLOTS = 6;

  typedef struct packed {
    logic [3:0]  class_value;
    logic [7:0]  class_bit;
    logic [11:0] hue_tenths;
    logic [8:0]  inv_saturation;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  yrc_stream_if #(24) pix (clk);
  yrc_stream_if #(33) verd (clk);
  yrc_cfg_if cfg (clk);

  verdict_t verd_beat;
  assign verd.data = verd_beat;

  yuv_rule_color_classifier uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(pix.valid), .in_ready(pix.ready),
    .in_luma(pix.data[23:16]), .in_chroma_u(pix.data[15:8]), .in_chroma_v(pix.data[7:0]),
    .out_valid(verd.valid), .out_ready(verd.ready),
    .out_class_value(verd_beat.class_value), .out_class_bit(verd_beat.class_bit),
    .out_hue_tenths(verd_beat.hue_tenths), .out_inv_saturation(verd_beat.inv_saturation),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata)
  );

  // local copy of the register file
  logic [47:0] rules_reg;
  logic [2:0]  count_reg;
  logic [45:0] slice_reg [RULE_SLOTS];

  logic [23:0] pixels_pending [$];
  verdict_t    verdicts_due [$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;        // no idling on either side
  bit          hold_request = 1'b0; // one long receiver stall
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          pix_took = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("yuv_rule_color_classifier_test NOT OK");
    $finish;
  end

  function automatic longint clamp_chan(longint x);
    longint top;
    top = longint'(255) << FB;
    if (x < 0) return 0;
    if (x > top) return top;
    return x;
  endfunction

  // full predictor: colour conversion, hue, inverted saturation, rule walk
  function automatic verdict_t classify_pixel(logic [23:0] px);
    longint y, u, v, r, g, b, mx, mn, d, num, hue, sat, ds, dl, d2;
    int unsigned n;
    logic [3:0] cls;
    bit done;
    verdict_t res;
    y = longint'(px[23:16]);
    u = longint'(px[15:8]) - 128;
    v = longint'(px[7:0]) - 128;
    r = clamp_chan((y <<< FB) + K_RV * v);
    g = clamp_chan((y <<< FB) - K_GU * u - K_GV * v);
    b = clamp_chan((y <<< FB) + K_BU * u);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) begin
      hue = yrc_pkg::HueNone;
    end else if (mx == r) begin
      num = 600 * (g - b) + 3600 * d;
      hue = num / d;
      if (hue > 3600) hue -= 3600;
    end else if (mx == g) begin
      num = 600 * (b - r) + 1200 * d;
      hue = num / d;
    end else begin
      num = 600 * (r - g) + 2400 * d;
      hue = num / d;
    end
    // zero luma saturates the ratio
    if (y == 0) sat = yrc_pkg::SatMax;
    else begin
      sat = (mn * 256) / (y <<< FB);
      if (sat > yrc_pkg::SatMax) sat = yrc_pkg::SatMax;
    end
    cls = 4'd0;
    done = 1'b0;
    if (y < longint'(rules_reg[43:35])) begin
      cls = rules_reg[47:44];
      done = 1'b1;
    end
    if (!done) begin
      ds = 24 - sat;
      dl = 128 - y;
      d2 = ds * ds + dl * dl;
      // a count above the slot total falls back to all slots
      n = (count_reg > RULE_SLOTS) ? RULE_SLOTS : count_reg;
      for (int i = 0; i < n; i++) begin
        if (!done && longint'(slice_reg[i][11:0]) < hue && hue < longint'(slice_reg[i][23:12])
            && d2 < longint'(slice_reg[i][41:24])) begin
          cls = slice_reg[i][45:42];
          done = 1'b1;
        end
      end
    end
    if (!done) begin
      ds = 256 - sat;
      dl = 256 - y;
      d2 = ds * ds + dl * dl;
      if (d2 < longint'(rules_reg[17:0])) begin
        cls = rules_reg[21:18];
        done = 1'b1;
      end
    end
    if (!done && sat > longint'(rules_reg[30:22])) cls = rules_reg[34:31];
    res.class_value = cls;
    // classes above eight fall off the mask
    res.class_bit = (cls == 0) ? 8'd0 : 8'((32'd1 << (cls - 1)));
    res.hue_tenths = 12'(hue);
    res.inv_saturation = 9'(sat);
    return res;
  endfunction

  // accepted beats on both data channels, sampled at the rising edge
  always @(posedge clk) begin
    verdict_t want;
    pix_took <= pix.valid && pix.ready;
    if (rst_n && pix.valid && pix.ready)
      verdicts_due = {verdicts_due, classify_pixel(pix.data)};
    if (rst_n && verd.valid && verd.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, verd_beat);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (want.class_value !== verd_beat.class_value) begin
          $display("%0t: class_value expected %0d actual %0d", $time, want.class_value,
                   verd_beat.class_value);
          mismatches++;
        end
        if (want.class_bit !== verd_beat.class_bit) begin
          $display("%0t: class_bit expected %h actual %h", $time, want.class_bit,
                   verd_beat.class_bit);
          mismatches++;
        end
        if (want.hue_tenths !== verd_beat.hue_tenths) begin
          $display("%0t: hue_tenths expected %0d actual %0d", $time, want.hue_tenths,
                   verd_beat.hue_tenths);
          mismatches++;
        end
        if (want.inv_saturation !== verd_beat.inv_saturation) begin
          $display("%0t: inv_saturation expected %0d actual %0d", $time,
                   want.inv_saturation, verd_beat.inv_saturation);
          mismatches++;
        end
      end
    end
  end

  // pixel driver: holds a beat until taken, idles in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (pix.valid && !pix_took) begin
      // beat still on offer
    end else if (gap_left > 0) begin
      pix.valid <= 1'b0;
      gap_left--;
    end else if (pixels_pending.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
      pix.valid <= 1'b0;
      gap_left = $urandom_range(0, 12);
    end else if (pixels_pending.size() > 0) begin
      pix.valid <= 1'b1;
      pix.data <= pixels_pending.pop_front();
    end else begin
      pix.valid <= 1'b0;
    end
  end

  // result receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      verd.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      verd.ready <= 1'b0;
      hold_request = 1'b0;
      hold_left = 300;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      verd.ready <= 1'b0;
      hold_left = $urandom_range(0, 12);
    end else begin
      verd.ready <= 1'b1;
    end
  end

  task automatic add_pixel(logic [23:0] px);
    pixels_pending = {pixels_pending, px};
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      yrc_pkg::CfgRule:  rules_reg = val;
      yrc_pkg::CfgCount: count_reg = val[2:0];
      default:           slice_reg[idx - yrc_pkg::CfgClass0] = val[45:0];
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // wait for the pipe to drain so that registers change only while idle
  task automatic drain_pipe();
    while (pixels_pending.size() > 0 || verdicts_due.size() > 0 || pix.valid) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  task automatic load_rules(int unsigned mode);
    logic [47:0] w;
    logic [11:0] lo, hi;
    int unsigned span;
    if (mode == 1) w = '1;
    else if (mode == 2) w = '0;
    else begin
      w = 48'({$urandom, $urandom});
      w[43:35] = 9'($urandom_range(0, 40));
      w[30:22] = 9'($urandom_range(0, 511));
    end
    write_reg(yrc_pkg::CfgRule, w);
    write_reg(yrc_pkg::CfgCount,
              48'(mode == 1 ? 3'd7 : mode == 2 ? 3'd0 : 3'($urandom_range(0, 7))));
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (mode == 1) w = '1;
      else if (mode == 2) w = '0;
      else begin
        w = 48'({$urandom, $urandom});
        lo = 12'($urandom_range(0, 3600));
        span = $urandom_range(0, 1500);
        hi = (32'(lo) + span > 4095) ? 12'd4095 : 12'(32'(lo) + span);
        w[11:0] = lo;
        w[23:12] = hi;
      end
      write_reg(yrc_pkg::CfgClass0 + 3'(i), w);
    end
  endtask

  task automatic queue_random(int unsigned count);
    logic [23:0] px;
    repeat (count) begin
      px = 24'($urandom);
      case ($urandom_range(0, 9))
        0: px[15:0] = 16'h8080;             // gray pixel
        1: px[23:16] = 8'd0;                // zero luma
        2: px[23:16] = 8'($urandom_range(0, 40));
        default: ;
      endcase
      add_pixel(px);
    end
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.data = '0;
    verd.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = yrc_pkg::CfgRule;
    cfg.wdata = '0;
    rules_reg = '0;
    count_reg = '0;
    for (int i = 0; i < RULE_SLOTS; i++) slice_reg[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners with reset registers
    add_pixel(24'h000000);
    add_pixel(24'hffffff);
    add_pixel(24'h008080);
    add_pixel(24'hff8080);
    add_pixel(24'h808080);
    add_pixel(24'h8000ff);
    add_pixel(24'h80ff00);
    add_pixel(24'h80ffff);
    add_pixel(24'h800000);
    drain_pipe();

    // corner and random pixels with all fields at their maximum
    load_rules(1);
    add_pixel(24'h000000);
    add_pixel(24'hffffff);
    add_pixel(24'h808080);
    add_pixel(24'hff00ff);
    add_pixel(24'h01ff00);
    add_pixel(24'h40a050);
    queue_random(200);
    drain_pipe();

    load_rules(2);
    queue_random(150);
    drain_pipe();

    for (int p = 0; p < 5; p++) begin
      load_rules(0);
      if (p == 2) hold_request = 1'b1;
      if (p == 4) calm = 1'b1;
      queue_random(250);
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("yuv_rule_color_classifier_test OK");
    end else begin
      $display("yuv_rule_color_classifier_test NOT OK");
    end
    $finish;
  end
endmodule

>>> yuv_rule_color_classifier.f
+incdir+rtl
rtl/yrc_pkg.sv
rtl/yrc_stream_if.sv
rtl/yrc_cfg_if.sv
rtl/yrc_divider.sv
rtl/yuv_rule_color_classifier.sv
verif/yuv_rule_color_classifier_test.sv
